>>> rtl/core/lzcd_pkg.sv
// ----------------------------------------------------------------------------
// lzcd_pkg: shared types and constants of the zero-crossing detector
// Register map, stream field widths, command codes and the per-item record
// that travels from the control stage to the window stage.
// ----------------------------------------------------------------------------
package lzcd_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Frame limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  // Configuration register widths and reset values
  localparam int CFG_W_BITS       = 11;
  localparam int CFG_H_BITS       = 13;
  localparam int CFG_DATA_BITS    = 32;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 480;

  // Stream field widths
  localparam int RESP_BITS     = 16;
  localparam int ROW_BITS      = 12;
  localparam int COL_BITS      = 10;
  localparam int OUT_DATA_BITS = 24;

  // Register indexes (byte address 4*index)
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lzcd_reg_t;

  // Input command carried on tuser
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } lzcd_cmd_t;

  // Record of one accepted transaction on its way to the output
  typedef struct packed {
    logic [ROW_BITS-1:0] row;        // row of the reported pixel
    logic [COL_BITS-1:0] col;        // column of the reported pixel
    logic                frame_end;  // last pixel of the frame
    logic                chk;        // interior and aligned: test the window
    logic                emit;       // transaction yields a mark
    logic                smp;        // transaction carries a sample
  } lzcd_mark_t;

endpackage

>>> rtl/core/lzcd_ram.sv
// ----------------------------------------------------------------------------
// lzcd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module lzcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/core/lzcd_ctrl.sv
// ----------------------------------------------------------------------------
// lzcd_ctrl: position, pending count and issue stage
// Tracks the input and report positions in the frame, decides per transaction
// whether a mark leaves, issues the line store read and holds the result
// record in the issue register until the window stage takes it.
// ----------------------------------------------------------------------------
module lzcd_ctrl
  import lzcd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CFG_W_BITS-1:0]  image_width,
  input  logic [CFG_H_BITS-1:0]  image_height,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_cmd,
  input  logic [RESP_BITS-1:0]   in_response,
  input  logic                   out_busy,
  output logic                   s1_adv,
  output logic                   s1_valid,
  output lzcd_mark_t             s1_mark,
  output logic [SAMPLE_BITS-1:0] s1_sample,
  output logic [CW-1:0]          s1_idx,
  output logic                   rd_en,
  output logic [CW-1:0]          rd_addr
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WB > CFG_W_BITS) ? WB : CFG_W_BITS;
  localparam int RW = ROW_BITS + 1;

  typedef struct packed {
    logic [CW-1:0]       col;
    logic [ROW_BITS-1:0] row;
  } pos_t;

  // Wrap a position that has run past the row or frame bounds
  function automatic pos_t wrap_pos(input logic [EW-1:0] c, input logic [RW-1:0] r,
                                    input logic [EW-1:0] w, input logic [RW-1:0] h);
    pos_t          p;
    logic [EW-1:0] cc;
    logic [RW-1:0] rr;
    cc = c;
    rr = r;
    if (cc >= w) begin
      cc = '0;
      rr = rr + RW'(1);
    end
    if (rr >= h) begin
      rr = '0;
    end
    p.col = cc[CW-1:0];
    p.row = rr[ROW_BITS-1:0];
    return p;
  endfunction

  logic [CW-1:0]       in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_BITS-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [EW-1:0]       pending_r, pending_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  lzcd_mark_t          s1_mark_r, mark_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CW-1:0]       s1_idx_r;

  logic [EW-1:0] eff_w, iw_e;
  logic [RW-1:0] eff_h;
  pos_t          in_w, out_w, in_a, out_a;
  logic          acc, is_flush, border, aligned, fend;

  // Clamp the frame size to its legal range
  always_comb begin
    iw_e = EW'(image_width);
    if (image_width < CFG_W_BITS'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (iw_e > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = iw_e;
    end
    if (image_height < CFG_H_BITS'(MIN_DIM)) begin
      eff_h = RW'(MIN_DIM);
    end else if (image_height > CFG_H_BITS'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(image_height);
    end
  end

  // Wrapped and advanced positions
  always_comb begin
    in_w  = wrap_pos(EW'(in_col_r), RW'(in_row_r), eff_w, eff_h);
    out_w = wrap_pos(EW'(out_col_r), RW'(out_row_r), eff_w, eff_h);
    in_a  = wrap_pos(EW'(in_w.col) + EW'(1), RW'(in_w.row), eff_w, eff_h);
    out_a = wrap_pos(EW'(out_w.col) + EW'(1), RW'(out_w.row), eff_w, eff_h);
  end

  // Border, alignment and frame end of the pixel to report
  always_comb begin
    border  = (out_w.row == '0) || (RW'(out_w.row) >= eff_h - RW'(1)) ||
              (out_w.col == '0) || (EW'(out_w.col) >= eff_w - EW'(1));
    aligned = (RW'(out_w.row) + RW'(1) == RW'(in_w.row)) &&
              (EW'(out_w.col) + EW'(1) == EW'(in_w.col));
    fend    = (RW'(out_w.row) == eff_h - RW'(1)) &&
              (EW'(out_w.col) == eff_w - EW'(1));
  end

  // Handshake of the issue register
  assign s1_adv    = s1_valid_r && !(s1_mark_r.emit && out_busy);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;
  assign is_flush  = (lzcd_cmd_t'(in_cmd) == CMD_FLUSH);

  // Next positions, pending count and result record
  always_comb begin
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    pending_nxt   = pending_r;
    mark_nxt.row       = out_w.row;
    mark_nxt.col       = COL_BITS'(out_w.col);
    mark_nxt.frame_end = fend;
    mark_nxt.chk       = 1'b0;
    mark_nxt.emit      = 1'b0;
    mark_nxt.smp       = !is_flush;
    if (acc) begin
      in_col_nxt  = in_w.col;
      in_row_nxt  = in_w.row;
      out_col_nxt = out_w.col;
      out_row_nxt = out_w.row;
      if (is_flush) begin
        if (pending_r != '0) begin
          mark_nxt.emit = 1'b1;
          out_col_nxt   = out_a.col;
          out_row_nxt   = out_a.row;
          pending_nxt   = pending_r - EW'(1);
        end
      end else begin
        in_col_nxt = in_a.col;
        in_row_nxt = in_a.row;
        if (pending_r > eff_w) begin
          mark_nxt.emit = 1'b1;
          mark_nxt.chk  = !border && aligned;
          out_col_nxt   = out_a.col;
          out_row_nxt   = out_a.row;
        end else begin
          pending_nxt = pending_r + EW'(1);
        end
      end
    end
  end

  // Occupancy of the issue register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = mark_nxt.emit || !is_flush;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pending_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      pending_r  <= pending_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Issue register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mark_r   <= mark_nxt;
      s1_sample_r <= SAMPLE_BITS'(in_response);
      s1_idx_r    <= in_w.col;
    end
  end

  assign rd_en     = acc && !is_flush;
  assign rd_addr   = in_w.col;
  assign s1_valid  = s1_valid_r;
  assign s1_mark   = s1_mark_r;
  assign s1_sample = s1_sample_r;
  assign s1_idx    = s1_idx_r;

endmodule

>>> rtl/core/lzcd_window.sv
// ----------------------------------------------------------------------------
// lzcd_window: 3x3 neighbourhood and sign test
// Shifts the two line store values and the new sample into the window and
// tests the new centre against its eight neighbours for a sign change.
// ----------------------------------------------------------------------------
module lzcd_window #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  logic [SAMPLE_BITS-1:0] up2,
  input  logic [SAMPLE_BITS-1:0] up1,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   chk,
  output logic                   mark_edge
);

  logic [SAMPLE_BITS-1:0] win_r   [3][3];
  logic [SAMPLE_BITS-1:0] win_nxt [3][3];
  logic                   c_neg, c_pos, n_neg, n_pos, hit;

  // Shift columns left, load the new column on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[i][k] = win_r[i][k];
      end
    end
    if (upd) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = up2;
      win_nxt[1][2] = up1;
      win_nxt[2][2] = sample;
    end
  end

  // Look for a neighbour of opposite strict sign
  always_comb begin
    c_neg = win_nxt[1][1][SAMPLE_BITS-1];
    c_pos = !c_neg && (|win_nxt[1][1]);
    hit   = 1'b0;
    n_neg = 1'b0;
    n_pos = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        n_neg = win_nxt[i][k][SAMPLE_BITS-1];
        n_pos = !n_neg && (|win_nxt[i][k]);
        if (!(i == 1 && k == 1)) begin
          hit = hit | (c_pos && n_neg) | (c_neg && n_pos);
        end
      end
    end
  end

  assign mark_edge = chk && hit;

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[i][k] <= '0;
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[i][k] <= win_nxt[i][k];
        end
      end
    end
  end

endmodule

>>> rtl/core/log_zero_crossing_detector_unit.sv
// ----------------------------------------------------------------------------
// log_zero_crossing_detector_unit: 3x3 zero-crossing marker
// Marks pixels of a raster stream of signed filtered responses whose strict
// sign differs from that of some 8-neighbour.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per pixel in raster order; tuser = 0 carries a
//           response in tdata, tuser = 1 is a flush that pushes out the
//           oldest pending mark (or nothing when none is pending).
//   out_* : one mark per pixel, image_width+1 samples behind its input, in
//           raster order; tlast flags the last pixel of a frame.
//   cfg_* : APB registers image_width (0x0) and image_height (0x4); write
//           them only while the block is idle.
// Path: a mark released by a transaction passes the issue register (with the
//   line store read), then the output register.
// Throughput: one transaction per cycle while out_tready stays high; each
//   sample does one read and one write of each line store, and a read and a
//   write in the same cycle are to different addresses.
// Reset: positions, pending count, window and handshake state clear at once;
//   line stores are not cleared.
// Stall: with out_tready low the output register holds its mark, the issue
//   register holds the next one, and in_tready drops until the mark is taken.
// ----------------------------------------------------------------------------
module log_zero_crossing_detector_unit
  import lzcd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [RESP_BITS-1:0]     in_tdata,    // [15:0] response
  input  logic                     in_tuser,    // [0] cmd
  // Mark stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,   // [11:0] row, [21:12] col,
                                                // [22] edge_res, [23] zero
  output logic                     out_tlast,   // frame_end
  // Configuration
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_W_BITS-1:0]  image_width_r;
  logic [CFG_H_BITS-1:0]  image_height_r;
  logic                   cfg_wr;

  logic                   out_busy, s1_adv, s1_valid, rd_en, ram_we, mark_edge;
  lzcd_mark_t             s1_mark;
  logic [SAMPLE_BITS-1:0] s1_sample, up1, up2;
  logic [CW-1:0]          s1_idx, rd_addr;

  logic                   out_v_r, out_v_nxt;
  logic [ROW_BITS-1:0]    out_row_r;
  logic [COL_BITS-1:0]    out_col_r;
  logic                   out_edge_r, out_fend_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= CFG_W_BITS'(IMAGE_WIDTH_RST);
      image_height_r <= CFG_H_BITS'(IMAGE_HEIGHT_RST);
    end else if (cfg_wr) begin
      case (lzcd_reg_t'(cfg_paddr[2]))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (lzcd_reg_t'(cfg_paddr[2]))
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DATA_BITS'(image_width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DATA_BITS'(image_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Position tracking and issue stage
  lzcd_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (in_tuser),
    .in_response  (in_tdata),
    .out_busy     (out_busy),
    .s1_adv       (s1_adv),
    .s1_valid     (s1_valid),
    .s1_mark      (s1_mark),
    .s1_sample    (s1_sample),
    .s1_idx       (s1_idx),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  // Line stores: a holds the row one back, b the row two back
  assign ram_we = s1_adv && s1_mark.smp;

  lzcd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (s1_sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (up1)
  );

  lzcd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (up1),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (up2)
  );

  // Neighbourhood window and sign test
  lzcd_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (ram_we),
    .up2       (up2),
    .up1       (up1),
    .sample    (s1_sample),
    .chk       (s1_mark.chk),
    .mark_edge (mark_edge)
  );

  // Output register: load a mark, drop it once taken
  assign out_busy = out_v_r && !out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv && s1_mark.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_mark.emit) begin
      out_row_r  <= s1_mark.row;
      out_col_r  <= s1_mark.col;
      out_edge_r <= mark_edge;
      out_fend_r <= s1_mark.frame_end;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_edge_r, out_col_r, out_row_r};
  assign out_tlast  = out_fend_r;

  // A line store write never meets a read of the same entry
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && rd_en) |-> (s1_idx != rd_addr))
    else $error("line store read and write hit the same entry");

  // Input back-pressure only comes from a stalled full output stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && out_v_r && !out_tready))
    else $error("input stalled without a full output stage");

  // The last pixel of a frame is a border pixel and is never marked
  a_frame_end_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_fend_r) |-> !out_edge_r)
    else $error("frame end pixel marked as zero crossing");

endmodule
